>>> rtl/bed_pkg.sv
// Shared types and constants for the button event debouncer.
// No dependencies.
package bed_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_SET   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   localparam int unsigned BTN_RESET = 0;
   localparam int unsigned BTN_NEXT  = 1;
   localparam int unsigned BTN_PREV  = 2;

   localparam int unsigned FLAG_RESET  = 0;
   localparam int unsigned FLAG_NEXT   = 1;
   localparam int unsigned FLAG_PREV   = 2;
   localparam int unsigned FLAG_HOME   = 3;
   localparam int unsigned FLAG_SLEEP  = 4;
   localparam int unsigned FLAG_IGNORE = 5;

   localparam int unsigned KEY_W  = 6;
   localparam int unsigned BTN_W  = 3;
   localparam int unsigned TICK_W = 16;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_SLEEP    = 2'd1,
      REG_PREV     = 2'd2,
      REG_UNUSED   = 2'd3
   } reg_index_type;

   localparam logic [7:0]  DEBOUNCE_RST = 8'd4;
   localparam logic [14:0] SLEEP_RST    = 15'd200;
   localparam logic        PREV_RST     = 1'b1;

   // True if a is later than b on the wrapping tick counter.
   function automatic logic after16(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
      logic [TICK_W-1:0] d;
      d = b - a;
      return d[TICK_W-1];
   endfunction

endpackage

>>> rtl/button_event_debouncer.sv
// Button event debouncer top level: key flag logic and registers; depends on bed_pkg.
// A request is registered in the input stage; key logic is a single pass to the result regs.
// Throughput: one request per cycle while the result is not stalled.
// A stalled result holds both stages; the input stalls only when both stages are full.
// Reset (synchronous, active high) clears tick, change time, button level and key flags,
// and loads a debounce of 4 ticks, a sleep hold of 200 ticks and prev present.
module button_event_debouncer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [2:0]                 req_raw_buttons,
   input  logic [5:0]                 req_key_mask,
   input  logic                       req_error_active,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [5:0]                 rsp_key_state,
   output logic                       rsp_blink_toggle,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bed_pkg::ADDR_W-1:0] paddr,
   input  logic [bed_pkg::DATA_W-1:0] pwdata,
   output logic [bed_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int unsigned TW = bed_pkg::TICK_W;

   // config registers
   logic [7:0]  debounce_ff;
   logic [14:0] sleep_ff;
   logic        prev_ff;
   bed_pkg::reg_index_type reg_idx;

   // state
   logic [TW-1:0]             tick_ff, tick_in;
   logic [TW-1:0]             lct_ff, lct_in;
   logic [bed_pkg::BTN_W-1:0] level_ff, level_in;
   logic [bed_pkg::KEY_W-1:0] keys_ff, keys_in;

   // input stage
   logic                      s1_valid_ff;
   bed_pkg::mode_type         s1_mode_ff;
   logic [bed_pkg::BTN_W-1:0] s1_raw_ff;
   logic [bed_pkg::KEY_W-1:0] s1_mask_ff;
   logic                      s1_err_ff;

   // result stage
   logic                      rsp_valid_ff;
   logic [bed_pkg::KEY_W-1:0] rsp_keys_ff;
   logic                      rsp_blink_ff, blink_in;

   logic advance, s1_adv, req_take;

   assign advance  = !(rsp_valid_ff && rsp_stall);
   assign s1_adv   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_state    = rsp_keys_ff;
   assign rsp_blink_toggle = rsp_blink_ff;

   // CSR port
   assign pready  = 1'b1;
   assign reg_idx = bed_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      case (reg_idx)
         bed_pkg::REG_DEBOUNCE: prdata = {24'd0, debounce_ff};
         bed_pkg::REG_SLEEP:    prdata = {17'd0, sleep_ff};
         bed_pkg::REG_PREV:     prdata = {31'd0, prev_ff};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= bed_pkg::DEBOUNCE_RST;
         sleep_ff    <= bed_pkg::SLEEP_RST;
         prev_ff     <= bed_pkg::PREV_RST;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_idx)
            bed_pkg::REG_DEBOUNCE: debounce_ff <= pwdata[7:0];
            bed_pkg::REG_SLEEP:    sleep_ff    <= pwdata[14:0];
            bed_pkg::REG_PREV:     prev_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // key logic
   logic [bed_pkg::BTN_W-1:0] raw;
   logic [bed_pkg::KEY_W-1:0] keys_j;
   logic [TW-1:0]             lct_j, tick_nx, deb_ext, sleep_ext;
   logic [bed_pkg::BTN_W-1:0] level_j;
   logic                      change, counts;

   always_comb begin
      deb_ext   = {8'd0, debounce_ff};
      sleep_ext = {1'b0, sleep_ff};
      raw       = s1_raw_ff;
      if (!prev_ff) raw[bed_pkg::BTN_PREV] = 1'b0;

      tick_in  = tick_ff;
      lct_in   = lct_ff;
      level_in = level_ff;
      keys_in  = keys_ff;
      blink_in = 1'b0;
      change   = 1'b0;
      counts   = 1'b0;
      keys_j   = keys_ff;
      lct_j    = lct_ff;
      level_j  = level_ff;
      tick_nx  = tick_ff + TW'(1);

      case (s1_mode_ff)
         bed_pkg::MODE_TICK: begin
            change = (raw != level_ff);
            counts = change && bed_pkg::after16(tick_ff, lct_ff + deb_ext);
            if (counts) begin
               if (keys_ff[bed_pkg::FLAG_IGNORE]) begin
                  keys_j[bed_pkg::FLAG_IGNORE] = 1'b0;
               end else if (!level_ff[bed_pkg::BTN_RESET] && raw[bed_pkg::BTN_RESET]) begin
                  keys_j[bed_pkg::FLAG_RESET] = 1'b1;
               end else if (prev_ff && !level_ff[bed_pkg::BTN_PREV]
                            && !level_ff[bed_pkg::BTN_NEXT]) begin
                  keys_j[bed_pkg::FLAG_HOME] = 1'b1;
               end else if (!level_ff[bed_pkg::BTN_NEXT] && raw[bed_pkg::BTN_NEXT]) begin
                  keys_j[bed_pkg::FLAG_NEXT] = 1'b1;
               end else if (prev_ff && !level_ff[bed_pkg::BTN_PREV]
                            && raw[bed_pkg::BTN_NEXT]) begin
                  keys_j[bed_pkg::FLAG_PREV] = 1'b1;
               end
            end
            if (change) begin
               lct_j   = tick_ff;
               level_j = raw;
            end
            tick_in  = tick_nx;
            blink_in = s1_err_ff && (tick_nx[3:0] == 4'd0);
            keys_in  = keys_j;
            lct_in   = lct_j;
            level_in = level_j;
            // long hold of next without prev held raises sleep and ignore once
            if (bed_pkg::after16(tick_nx, lct_j + deb_ext)
                && !level_j[bed_pkg::BTN_NEXT]
                && (!prev_ff || level_j[bed_pkg::BTN_PREV])
                && bed_pkg::after16(tick_nx, lct_j + sleep_ext)
                && !keys_j[bed_pkg::FLAG_SLEEP]) begin
               keys_in[bed_pkg::FLAG_SLEEP]  = 1'b1;
               keys_in[bed_pkg::FLAG_IGNORE] = 1'b1;
               lct_in = tick_nx;
            end
         end
         bed_pkg::MODE_CLEAR: keys_in = keys_ff & ~s1_mask_ff;
         bed_pkg::MODE_SET:   keys_in = keys_ff | s1_mask_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         lct_ff       <= '0;
         level_ff     <= '0;
         keys_ff      <= '0;
      end else begin
         if (advance) rsp_valid_ff <= s1_valid_ff;
         if (!req_stall) s1_valid_ff <= req_valid;
         if (s1_adv) begin
            tick_ff  <= tick_in;
            lct_ff   <= lct_in;
            level_ff <= level_in;
            keys_ff  <= keys_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= bed_pkg::mode_type'(req_mode);
         s1_raw_ff  <= req_raw_buttons;
         s1_mask_ff <= req_key_mask;
         s1_err_ff  <= req_error_active;
      end
      if (s1_adv) begin
         rsp_keys_ff  <= keys_in;
         rsp_blink_ff <= blink_in;
      end
   end

   // checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input stage");

   a_tick_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_mode_ff != bed_pkg::MODE_TICK) |=> tick_ff == $past(tick_ff))
      else $error("tick counter moved on a key flag request");

   a_blink_phase: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && tick_in[3:0] != 4'd0) |=> !rsp_blink_ff)
      else $error("blink pulse off its 16-tick phase");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_valid_ff) |=> !rsp_valid_ff)
      else $error("result appeared without a request");

endmodule

>>> tb/button_event_debouncer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_event_debouncer: predicts key flags and blink per request.
// Drives the request, result and APB-style register ports; depends on bed_pkg and the RTL top.
module button_event_debouncer_test;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;

   typedef struct packed {
      logic [5:0] key_state;
      logic       blink_toggle;
   } key_result_type;

   class key_event_scoreboard;
      logic [7:0]  debounce;
      logic [14:0] sleep_time;
      logic        prev_on;
      logic [15:0] tick;
      logic [15:0] last_change;
      logic [2:0]  level;
      logic [5:0]  keys;
      key_result_type expected_keys_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned sleep_events;
      int unsigned counted_changes;

      function new();
         reset_state();
         errors = 0;
         checked = 0;
         sleep_events = 0;
         counted_changes = 0;
      endfunction

      function void reset_state();
         debounce = bed_pkg::DEBOUNCE_RST;
         sleep_time = bed_pkg::SLEEP_RST;
         prev_on = bed_pkg::PREV_RST;
         tick = '0;
         last_change = '0;
         level = '0;
         keys = '0;
         expected_keys_q.delete();
      endfunction

      function void set_config(bed_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            bed_pkg::REG_DEBOUNCE: debounce = value[7:0];
            bed_pkg::REG_SLEEP: sleep_time = value[14:0];
            bed_pkg::REG_PREV: prev_on = value[0];
            default: ;
         endcase
      endfunction

      // a is later than b on the wrapping 16-bit tick counter
      function bit later_than(logic [15:0] a, logic [15:0] b);
         logic signed [15:0] gap;
         gap = b - a;
         return gap < 0;
      endfunction

      function void weigh_change(logic [2:0] fresh);
         if (later_than(tick, last_change + 16'(debounce))) begin
            counted_changes++;
            if (keys[bed_pkg::FLAG_IGNORE])
               keys[bed_pkg::FLAG_IGNORE] = 1'b0;
            else if (!level[bed_pkg::BTN_RESET] && fresh[bed_pkg::BTN_RESET])
               keys[bed_pkg::FLAG_RESET] = 1'b1;
            else if (prev_on && !level[bed_pkg::BTN_PREV] && !level[bed_pkg::BTN_NEXT])
               keys[bed_pkg::FLAG_HOME] = 1'b1;
            else if (!level[bed_pkg::BTN_NEXT] && fresh[bed_pkg::BTN_NEXT])
               keys[bed_pkg::FLAG_NEXT] = 1'b1;
            else if (prev_on && !level[bed_pkg::BTN_PREV] && fresh[bed_pkg::BTN_NEXT])
               keys[bed_pkg::FLAG_PREV] = 1'b1;
         end
         last_change = tick;
         level = fresh;
      endfunction

      function void note_request(bed_pkg::mode_type mode, logic [2:0] raw, logic [5:0] mask,
                                 logic err);
         key_result_type want;
         logic [2:0] fresh;
         want.blink_toggle = 1'b0;
         case (mode)
            bed_pkg::MODE_TICK: begin
               fresh = raw;
               if (!prev_on)
                  fresh[bed_pkg::BTN_PREV] = 1'b0;
               if (fresh != level)
                  weigh_change(fresh);
               tick = tick + 16'd1;
               want.blink_toggle = err && (tick[3:0] == 4'd0);
               if (later_than(tick, last_change + 16'(debounce)) && !level[bed_pkg::BTN_NEXT]
                   && (!prev_on || level[bed_pkg::BTN_PREV])
                   && later_than(tick, last_change + 16'(sleep_time))
                   && !keys[bed_pkg::FLAG_SLEEP]) begin
                  keys[bed_pkg::FLAG_SLEEP] = 1'b1;
                  keys[bed_pkg::FLAG_IGNORE] = 1'b1;
                  last_change = tick;
                  sleep_events++;
               end
            end
            bed_pkg::MODE_CLEAR: keys = keys & ~mask;
            bed_pkg::MODE_SET: keys = keys | mask;
            default: ;
         endcase
         want.key_state = keys;
         expected_keys_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         if (errors < 30)
            $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [5:0] got_keys, logic got_blink);
         key_result_type want;
         checked++;
         if (expected_keys_q.size() == 0) begin
            report_mismatch($sformatf("result keys=%h blink=%b with no request outstanding",
                                      got_keys, got_blink));
            return;
         end
         want = expected_keys_q.pop_front();
         if (got_keys !== want.key_state)
            report_mismatch($sformatf("key_state %h, expected %h", got_keys, want.key_state));
         if (got_blink !== want.blink_toggle)
            report_mismatch($sformatf("blink_toggle %b, expected %b", got_blink,
                                      want.blink_toggle));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [2:0]  req_raw_buttons;
   logic [5:0]  req_key_mask;
   logic        req_error_active;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_key_state;
   logic        rsp_blink_toggle;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   key_event_scoreboard sb;
   int unsigned sent;
   int unsigned settings_used;
   int unsigned cycle_count;
   int unsigned long_holds;
   bit          sender_fast;
   bit          receiver_fast;
   bit          hold_off_request;

   button_event_debouncer u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_raw_buttons(req_raw_buttons),
      .req_key_mask(req_key_mask),
      .req_error_active(req_error_active),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_key_state(rsp_key_state),
      .rsp_blink_toggle(rsp_blink_toggle),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("** button_event_debouncer: FAILED **");
      $finish;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 90)
         return $urandom_range(1, 2);
      if (r < 98)
         return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic int unsigned hold_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return $urandom_range(1, sb.debounce + 3);
      if (r < 65 && sb.sleep_time <= 400)
         return $urandom_range(sb.sleep_time, sb.sleep_time + sb.debounce + 4);
      return $urandom_range(1, 4);
   endfunction

   // result side: checks accepted results and stalls at random
   initial begin
      int unsigned stall_left;
      int unsigned idle;
      stall_left = 0;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_key_state, rsp_blink_toggle);
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            long_holds++;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (receiver_fast) begin
            rsp_stall <= 1'b0;
         end else begin
            idle = idle_len();
            if (idle != 0) begin
               stall_left = idle - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic send_request(bed_pkg::mode_type mode, logic [2:0] raw, logic [5:0] mask,
                               logic err);
      int unsigned gap;
      gap = sender_fast ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_raw_buttons <= raw;
      req_key_mask <= mask;
      req_error_active <= err;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, raw, mask, err);
      sent++;
   endtask

   task automatic write_reg(bed_pkg::reg_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_config(idx, value);
   endtask

   task automatic apply_settings(logic [7:0] deb, logic [14:0] slp, logic prv);
      req_valid <= 1'b0;
      while (sb.expected_keys_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(bed_pkg::REG_DEBOUNCE, {24'($urandom), deb});
      write_reg(bed_pkg::REG_SLEEP, {17'($urandom), slp});
      write_reg(bed_pkg::REG_PREV, {31'($urandom), prv});
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned stop;
      int unsigned pick;
      int unsigned hold;
      int unsigned i;
      logic [2:0] combo;
      logic err;
      stop = sent + n;
      while (sent < stop) begin
         pick = $urandom_range(0, 99);
         err = 1'($urandom_range(0, 1));
         if (pick < 65) begin
            case ($urandom_range(0, 5))
               0: combo = 3'b110;
               1: combo = 3'b101;
               2: combo = 3'b011;
               3: combo = 3'b001;
               default: combo = 3'($urandom_range(0, 7));
            endcase
            hold = hold_len();
            for (i = 0; i < hold; i++) begin
               if (i == 1 && $urandom_range(0, 4) == 0)
                  send_request(bed_pkg::MODE_TICK, 3'($urandom_range(0, 7)), 6'($urandom), err);
               else
                  send_request(bed_pkg::MODE_TICK, combo, 6'($urandom), err);
            end
            combo = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
            hold = hold_len();
            for (i = 0; i < hold; i++)
               send_request(bed_pkg::MODE_TICK, combo, 6'($urandom), err);
         end else if (pick < 72) begin
            send_request(bed_pkg::MODE_SET, 3'($urandom), 6'($urandom), err);
         end else if (pick < 80) begin
            send_request(bed_pkg::MODE_CLEAR, 3'($urandom), 6'($urandom), err);
         end else if (pick < 85) begin
            send_request(bed_pkg::MODE_NONE, 3'($urandom), 6'($urandom), err);
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(bed_pkg::MODE_TICK, 3'($urandom), 6'($urandom), err);
         end
      end
   endtask

   initial begin
      sb = new();
      sent = 0;
      settings_used = 0;
      long_holds = 0;
      sender_fast = 1'b1;
      receiver_fast = 1'b1;
      hold_off_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= bed_pkg::MODE_NONE;
      req_raw_buttons <= 3'b111;
      req_key_mask <= '0;
      req_error_active <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sb.reset_state();
      @(posedge clock);

      // directed: each key rule, sleep then ignore, software flags, prev absent
      apply_settings(8'd0, 15'd3, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h3F, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b0);
      send_request(bed_pkg::MODE_TICK, 3'b110, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b101, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b011, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b001, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_CLEAR, 3'b000, 6'h3F, 1'b1);
      repeat (5) send_request(bed_pkg::MODE_TICK, 3'b101, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_SET, 3'b111, 6'h3F, 1'b0);
      send_request(bed_pkg::MODE_CLEAR, 3'b000, 6'h2A, 1'b1);
      send_request(bed_pkg::MODE_NONE, 3'b000, 6'h15, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b000, 6'h00, 1'b1);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b1);
      apply_settings(8'd7, 15'd3, 1'b0);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b0);
      send_request(bed_pkg::MODE_TICK, 3'b111, 6'h00, 1'b0);
      send_request(bed_pkg::MODE_TICK, 3'b110, 6'h00, 1'b0);

      sender_fast = 1'b0;
      receiver_fast = 1'b0;
      apply_settings(8'd0, 15'd1, 1'b0);
      random_phase(100);
      apply_settings(bed_pkg::DEBOUNCE_RST, bed_pkg::SLEEP_RST, bed_pkg::PREV_RST);
      random_phase(150);
      apply_settings(8'd255, 15'd32767, 1'b1);
      random_phase(200);
      repeat (3) begin
         apply_settings(8'($urandom_range(0, 12)), 15'($urandom_range(1, 60)),
                        1'($urandom_range(0, 1)));
         random_phase(80);
      end

      // output held off while requests keep coming
      apply_settings(8'd1, 15'd5, 1'b1);
      sender_fast = 1'b1;
      hold_off_request = 1'b1;
      repeat (30) send_request(bed_pkg::MODE_TICK, 3'($urandom), 6'($urandom), 1'($urandom));
      sender_fast = 1'b0;
      random_phase(100);

      req_valid <= 1'b0;
      while (sb.expected_keys_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.expected_keys_q.size() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_keys_q.size()));
      $display("%0d requests under %0d register settings, %0d results checked, %0d long holds",
               sent, settings_used, sb.checked, long_holds);
      $display("%0d counted button changes and %0d sleep events seen",
               sb.counted_changes, sb.sleep_events);
      if (sb.errors == 0)
         $display("** button_event_debouncer: PASSED **");
      else
         $display("** button_event_debouncer: FAILED **");
      $finish;
   end

endmodule
